// File: sv/dfs_pkg.sv
// shared types and constants for the depth-first search block
// used by the interfaces, the controller, the datapath and the checker
package dfs_pkg;

	localparam int MAX_VERTICES_DEF = 16;

	// field widths
	localparam int VTX_W      = 4;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT = 1'b0,
		CFG_UNDIRECTED   = 1'b1
	} cfg_idx_t;

	// item command codes
	localparam logic CMD_EDGE   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// register reset values
	localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd16;
	localparam logic             UNDIRECTED_RST   = 1'b1;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;
		logic adj_rd_from;
		logic adj_wr_from;
		logic adj_rd_to;
		logic adj_wr_to;
		logic search_start;
		logic push;
		logic pop;
		logic pop_load;
		logic emit_bad;
		logic emit_last;
	} dfs_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic is_search;
		logic edge_ok;
		logic undirected;
		logic start_bad;
		logic found;
		logic last_pop;
		logic out_free;
	} dfs_sts_t;

endpackage

// File: sv/dfs_ifs.sv
// channel interfaces: command items, result items and configuration writes
// depends on dfs_pkg for field widths
interface dfs_cmd_if;
	import dfs_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 command;
	logic [VTX_W-1:0]     from_vertex;
	logic [VTX_W-1:0]     to_vertex;
	logic                 edge_present;
	logic [VTX_W-1:0]     start_vertex;
	modport source (output valid, command, from_vertex, to_vertex, edge_present,
		start_vertex, input ready);
	modport sink (input valid, command, from_vertex, to_vertex, edge_present,
		start_vertex, output ready);
endinterface

interface dfs_res_if;
	import dfs_pkg::*;
	logic             valid;
	logic             ready;
	logic [VTX_W-1:0] vertex;
	logic             last;
	logic             bad_start;
	modport source (output valid, vertex, last, bad_start, input ready);
	modport sink (input valid, vertex, last, bad_start, output ready);
endinterface

interface dfs_cfg_if;
	import dfs_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: sv/dfs_ram.sv
// generic single-write, single-read memory with registered read data
// no dependencies
module dfs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: sv/dfs_ctrl.sv
// controller state machine for edge writes and the depth-first walk
// depends on dfs_pkg for the command and status structs
module dfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  dfs_pkg::dfs_sts_t sts,
	output dfs_pkg::dfs_cmd_t ctl
);
	import dfs_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_DECODE = 9'b000000010,
		ST_EW_WR1 = 9'b000000100,
		ST_EW_RD2 = 9'b000001000,
		ST_EW_WR2 = 9'b000010000,
		ST_BAD    = 9'b000100000,
		ST_SCAN   = 9'b001000000,
		ST_POP    = 9'b010000000,
		ST_DONE   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.latch_in = 1'b1;
					state_nxt    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!sts.is_search) begin
					if (sts.edge_ok) begin
						ctl.adj_rd_from = 1'b1;
						state_nxt       = ST_EW_WR1;
					end else begin
						state_nxt = ST_IDLE;
					end
				end else if (sts.start_bad) begin
					state_nxt = ST_BAD;
				end else begin
					ctl.search_start = 1'b1;
					state_nxt        = ST_SCAN;
				end
			end
			ST_EW_WR1: begin
				ctl.adj_wr_from = 1'b1;
				state_nxt       = sts.undirected ? ST_EW_RD2 : ST_IDLE;
			end
			ST_EW_RD2: begin
				ctl.adj_rd_to = 1'b1;
				state_nxt     = ST_EW_WR2;
			end
			ST_EW_WR2: begin
				ctl.adj_wr_to = 1'b1;
				state_nxt     = ST_IDLE;
			end
			ST_BAD: begin
				if (sts.out_free) begin
					ctl.emit_bad = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				// push the found neighbor, step back to the parent, or finish at the start vertex
				if (sts.found) begin
					if (sts.out_free) begin
						ctl.push = 1'b1;
					end
				end else if (sts.last_pop) begin
					state_nxt = ST_DONE;
				end else begin
					ctl.pop   = 1'b1;
					state_nxt = ST_POP;
				end
			end
			ST_POP: begin
				ctl.pop_load = 1'b1;
				state_nxt    = ST_SCAN;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					ctl.emit_last = 1'b1;
					state_nxt     = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// File: sv/dfs_dp.sv
// datapath: adjacency and stack memories, visited set, scan and result register
// depends on dfs_pkg, dfs_ifs and dfs_ram
module dfs_dp #(
	parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        command,
	input  logic [dfs_pkg::VTX_W-1:0]   from_vertex,
	input  logic [dfs_pkg::VTX_W-1:0]   to_vertex,
	input  logic                        edge_present,
	input  logic [dfs_pkg::VTX_W-1:0]   start_vertex,
	dfs_cfg_if.sink                     cfg,
	dfs_res_if.source                   res,
	input  dfs_pkg::dfs_cmd_t           ctl,
	output dfs_pkg::dfs_sts_t           sts
);
	import dfs_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int CW = (NW > CNT_W) ? NW : CNT_W;

	// latched item fields
	logic             command_q;
	logic [VTX_W-1:0] from_q;
	logic [VTX_W-1:0] to_q;
	logic             present_q;
	logic [VTX_W-1:0] start_q;

	// configuration registers
	logic [CNT_W-1:0] vcount_q;
	logic             undirected_q;

	// search state
	logic [MAX_VERTICES-1:0] visited_q;
	logic [NW-1:0]           sp_q;
	logic [NW-1:0]           scan_q;
	logic [VW-1:0]           top_q;
	logic [VW-1:0]           pend_q;

	// result register
	logic             out_valid_q;
	logic [VTX_W-1:0] out_vertex_q;
	logic             out_last_q;
	logic             out_bad_q;

	// memory ports
	logic                    adj_rd_en;
	logic [VW-1:0]           adj_rd_addr;
	logic [MAX_VERTICES-1:0] row;
	logic                    adj_wr_en;
	logic [VW-1:0]           adj_wr_addr;
	logic [MAX_VERTICES-1:0] adj_wr_data;
	logic                    stk_wr_en;
	logic [VW-1:0]           stk_wr_addr;
	logic [VW-1:0]           stk_wr_data;
	logic [VW-1:0]           stk_rd_data;

	// decoded vertices and scan results
	logic [CW-1:0]           n_eff;
	logic [MAX_VERTICES-1:0] from_bit;
	logic [MAX_VERTICES-1:0] to_bit;
	logic [MAX_VERTICES-1:0] start_bit;
	logic [MAX_VERTICES-1:0] set_bit;
	logic [MAX_VERTICES-1:0] cand;
	logic [MAX_VERTICES-1:0] found_bit;
	logic [VW-1:0]           found_idx;
	logic                    found;
	logic                    emit;

	// effective vertex count, capped at the matrix size
	assign n_eff = (CW'(vcount_q) > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_q);

	// one-hot decode of the item vertices
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			from_bit[i]  = (CW'(i) == CW'(from_q));
			to_bit[i]    = (CW'(i) == CW'(to_q));
			start_bit[i] = (CW'(i) == CW'(start_q));
		end
	end

	// unvisited neighbors of the top vertex from the scan point up
	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			cand[i] = row[i] & ~visited_q[i] & (NW'(i) >= scan_q) & (CW'(i) < n_eff);
		end
	end

	// lowest candidate wins
	assign found_bit = cand & (~cand + MAX_VERTICES'(1));
	always_comb begin
		found_idx = '0;
		for (int i = 0; i < MAX_VERTICES; i++) begin
			if (found_bit[i]) begin
				found_idx = VW'(i);
			end
		end
	end
	assign found = |cand;

	// adjacency read address select
	always_comb begin
		adj_rd_en = ctl.adj_rd_from | ctl.adj_rd_to | ctl.search_start | ctl.push | ctl.pop_load;
		if (ctl.adj_rd_to) begin
			adj_rd_addr = VW'(to_q);
		end else if (ctl.search_start) begin
			adj_rd_addr = VW'(start_q);
		end else if (ctl.push) begin
			adj_rd_addr = found_idx;
		end else if (ctl.pop_load) begin
			adj_rd_addr = stk_rd_data;
		end else begin
			adj_rd_addr = VW'(from_q);
		end
	end

	// read-modify-write of one adjacency bit
	assign adj_wr_en   = ctl.adj_wr_from | ctl.adj_wr_to;
	assign adj_wr_addr = ctl.adj_wr_to ? VW'(to_q) : VW'(from_q);
	assign set_bit     = ctl.adj_wr_to ? from_bit : to_bit;
	assign adj_wr_data = present_q ? (row | set_bit) : (row & ~set_bit);

	dfs_ram #(
		.WIDTH (MAX_VERTICES),
		.DEPTH (MAX_VERTICES)
	) u_adj_ram (
		.clk     (clk),
		.wr_en   (adj_wr_en),
		.wr_addr (adj_wr_addr),
		.wr_data (adj_wr_data),
		.rd_en   (adj_rd_en),
		.rd_addr (adj_rd_addr),
		.rd_data (row)
	);

	// vertex stack, read one below the top on a pop
	assign stk_wr_en   = ctl.search_start | ctl.push;
	assign stk_wr_addr = ctl.search_start ? '0 : VW'(sp_q);
	assign stk_wr_data = ctl.search_start ? VW'(start_q) : found_idx;

	dfs_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_VERTICES)
	) u_stk_ram (
		.clk     (clk),
		.wr_en   (stk_wr_en),
		.wr_addr (stk_wr_addr),
		.wr_data (stk_wr_data),
		.rd_en   (ctl.pop),
		.rd_addr (VW'(sp_q - NW'(2))),
		.rd_data (stk_rd_data)
	);

	assign emit = ctl.push | ctl.emit_last | ctl.emit_bad;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= VERTEX_COUNT_RST;
			undirected_q <= UNDIRECTED_RST;
			visited_q    <= '0;
			sp_q         <= '0;
			scan_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				case (cfg_idx_t'(cfg.index))
					CFG_VERTEX_COUNT: vcount_q <= cfg.data;
					CFG_UNDIRECTED:   undirected_q <= cfg.data[0];
					default: ;
				endcase
			end
			if (ctl.search_start) begin
				visited_q <= start_bit;
				sp_q      <= NW'(1);
				scan_q    <= '0;
			end else if (ctl.push) begin
				visited_q <= visited_q | found_bit;
				sp_q      <= sp_q + NW'(1);
				scan_q    <= '0;
			end else if (ctl.pop) begin
				sp_q   <= sp_q - NW'(1);
				scan_q <= NW'(top_q) + NW'(1);
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.latch_in) begin
			command_q <= command;
			from_q    <= from_vertex;
			to_q      <= to_vertex;
			present_q <= edge_present;
			start_q   <= start_vertex;
		end
		if (ctl.search_start) begin
			top_q  <= VW'(start_q);
			pend_q <= VW'(start_q);
		end else if (ctl.push) begin
			top_q  <= found_idx;
			pend_q <= found_idx;
		end else if (ctl.pop_load) begin
			top_q <= stk_rd_data;
		end
		// previous vertex goes out once the next one is known
		if (ctl.push) begin
			out_vertex_q <= VTX_W'(pend_q);
			out_last_q   <= 1'b0;
			out_bad_q    <= 1'b0;
		end else if (ctl.emit_last) begin
			out_vertex_q <= VTX_W'(pend_q);
			out_last_q   <= 1'b1;
			out_bad_q    <= 1'b0;
		end else if (ctl.emit_bad) begin
			out_vertex_q <= start_q;
			out_last_q   <= 1'b1;
			out_bad_q    <= 1'b1;
		end
	end

	// status to the controller
	assign sts.is_search  = (command_q == CMD_SEARCH);
	assign sts.edge_ok    = (CW'(from_q) < CW'(MAX_VERTICES)) && (CW'(to_q) < CW'(MAX_VERTICES));
	assign sts.undirected = undirected_q;
	assign sts.start_bad  = (CW'(start_q) >= n_eff);
	assign sts.found      = found;
	assign sts.last_pop   = (sp_q == NW'(1));
	assign sts.out_free   = !out_valid_q || res.ready;

	// ports
	assign cfg.ready     = 1'b1;
	assign res.valid     = out_valid_q;
	assign res.vertex    = out_vertex_q;
	assign res.last      = out_last_q;
	assign res.bad_start = out_bad_q;

endmodule

// File: sv/dfs_adjacency_matrix_order.sv
// Depth-first search over an adjacency bit matrix, emitting vertices in visit order.
// Channels: cmd takes items (edge write or search), res gives result items,
// cfg writes vertex_count (index 0) and undirected (index 1), always ready.
// An edge write gives no result; it does a read-modify-write of one matrix row
// per direction, in both directions in undirected mode.
// A search does one scan per push (a priority pick over the row) and, per pop,
// a scan and then a reload of the parent's row from the stack, since the adjacency
// and stack memories each have a single read port.
// Each vertex is sent when the next one is found, so the final one carries last.
// A bad start gives one result with bad_start and last set after the decode state,
// held back while the output register still holds an earlier result not yet taken.
// One item is worked at a time; cmd.ready is high only while the block is free.
// Results sit in an output register; when res.ready is low the walk pauses
// at its next result and resumes without loss.
// Reset clears visited set, stack count, result valid and the configuration
// (16 vertices, undirected); matrix rows hold garbage until written.
// depends on dfs_pkg, dfs_ifs, dfs_ram, dfs_ctrl and dfs_dp
module dfs_adjacency_matrix_order #(
	parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	dfs_cmd_if.sink   cmd,
	dfs_res_if.source res,
	dfs_cfg_if.sink   cfg
);
	import dfs_pkg::*;

	dfs_cmd_t ctl;
	dfs_sts_t sts;
	logic     in_ready;

	assign cmd.ready = in_ready;

	// sequencer
	dfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.ctl      (ctl)
	);

	// storage and scan logic
	dfs_dp #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.command      (cmd.command),
		.from_vertex  (cmd.from_vertex),
		.to_vertex    (cmd.to_vertex),
		.edge_present (cmd.edge_present),
		.start_vertex (cmd.start_vertex),
		.cfg          (cfg),
		.res          (res),
		.ctl          (ctl),
		.sts          (sts)
	);

endmodule

// File: sv/dfs_chk.sv
// port-level checks for the depth-first search block, bound to the top level
// depends on dfs_pkg for field widths
module dfs_chk (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [dfs_pkg::VTX_W-1:0] vertex,
	input logic                      last,
	input logic                      bad_start
);
	import dfs_pkg::*;

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(vertex) && $stable(last)
			&& $stable(bad_start))
		else $error("result changed while stalled");

	// a bad start result always carries last, as the only result of its search
	a_bad_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_start |-> last)
		else $error("bad start result not marked last");

	// one item at a time: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while busy");

	// results only come out of work in progress
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while idle");

endmodule

bind dfs_adjacency_matrix_order dfs_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.vertex    (res.vertex),
	.last      (res.last),
	.bad_start (res.bad_start)
);

// File: tb/tb_dfs_adjacency_matrix_order.sv
// testbench for the depth-first search block: edge writes and searches go in as items,
// the visit order of every search is predicted and checked item by item
// depends on dfs_pkg, dfs_ifs and dfs_adjacency_matrix_order
module tb_dfs_adjacency_matrix_order;
	import dfs_pkg::*;

	localparam int NV          = MAX_VERTICES_DEF;
	localparam int IDLE_PCT    = 6;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 12;
	localparam int HOLD_CYCLES = 400;
	localparam int CFG_PAD_W   = CFG_DATA_W - 1;

	typedef struct packed {
		logic             command;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
		logic             edge_present;
		logic [VTX_W-1:0] start_vertex;
	} dfs_item_t;

	typedef struct packed {
		logic [VTX_W-1:0] vertex;
		logic             last;
		logic             bad_start;
	} visit_t;

	logic clk = 1'b0;
	logic arst_n;

	dfs_cmd_if cmd_ch();
	dfs_res_if res_ch();
	dfs_cfg_if cfg_ch();

	dfs_adjacency_matrix_order uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the graph and the registers
	logic [NV-1:0]    adj_rows [NV];
	logic [NV-1:0]    row_written [NV];
	logic [CNT_W-1:0] vc_reg;
	logic             undir_reg;

	// visit order still to arrive
	visit_t visit_q [$];

	int fail_count   = 0;
	int item_count   = 0;
	int search_count = 0;
	int bad_count    = 0;
	int result_count = 0;
	int idle_pct     = IDLE_PCT;

	// receiver hold-off requests
	int hold_req_cnt  = 0;
	int hold_done_cnt = 0;
	int hold_left     = 0;

	always #2 clk = ~clk;

	// visit order of one item, updates the shadow graph on edge writes
	function automatic void predict_visits(input dfs_item_t it);
		int n;
		int scan;
		int depth;
		int top;
		bit found;
		logic [NV-1:0] seen;
		logic [VTX_W-1:0] path [NV];
		if (it.command == CMD_EDGE) begin
			adj_rows[it.from_vertex][it.to_vertex] = it.edge_present;
			row_written[it.from_vertex][it.to_vertex] = 1'b1;
			if (undir_reg) begin
				adj_rows[it.to_vertex][it.from_vertex] = it.edge_present;
				row_written[it.to_vertex][it.from_vertex] = 1'b1;
			end
			return;
		end
		search_count++;
		n = (vc_reg > NV) ? NV : int'(vc_reg);
		if (int'(it.start_vertex) >= n) begin
			visit_q.push_back('{vertex: it.start_vertex, last: 1'b1, bad_start: 1'b1});
			bad_count++;
			return;
		end
		seen = '0;
		seen[it.start_vertex] = 1'b1;
		path[0] = it.start_vertex;
		depth = 1;
		scan = 0;
		visit_q.push_back('{vertex: it.start_vertex, last: 1'b0, bad_start: 1'b0});
		while (depth > 0) begin
			top = path[depth-1];
			found = 1'b0;
			// lowest unvisited neighbor at or above the scan point
			while (scan < n && !found) begin
				if (adj_rows[top][scan] && !seen[scan])
					found = 1'b1;
				else
					scan++;
			end
			if (found) begin
				seen[scan] = 1'b1;
				visit_q.push_back('{vertex: VTX_W'(scan), last: 1'b0, bad_start: 1'b0});
				if (depth < NV) begin
					path[depth] = VTX_W'(scan);
					depth++;
				end
				scan = 0;
			end else begin
				// back up and resume the parent's scan after the popped vertex
				scan = int'(path[depth-1]) + 1;
				depth--;
			end
		end
		visit_q[visit_q.size()-1].last = 1'b1;
	endfunction

	function automatic dfs_item_t edge_item(input int from_v, input int to_v, input bit present);
		dfs_item_t it;
		it.command      = CMD_EDGE;
		it.from_vertex  = VTX_W'(from_v);
		it.to_vertex    = VTX_W'(to_v);
		it.edge_present = present;
		it.start_vertex = VTX_W'($urandom_range(15));
		return it;
	endfunction

	function automatic dfs_item_t search_item(input int start_v);
		dfs_item_t it;
		it.command      = CMD_SEARCH;
		it.from_vertex  = VTX_W'($urandom_range(15));
		it.to_vertex    = VTX_W'($urandom_range(15));
		it.edge_present = 1'($urandom_range(1));
		it.start_vertex = VTX_W'(start_v);
		return it;
	endfunction

	// offer one item until it is taken, then predict its results
	task automatic send_item(input dfs_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= it.command;
		cmd_ch.from_vertex  <= it.from_vertex;
		cmd_ch.to_vertex    <= it.to_vertex;
		cmd_ch.edge_present <= it.edge_present;
		cmd_ch.start_vertex <= it.start_vertex;
		do begin
			@(posedge clk);
		end while (cmd_ch.ready !== 1'b1);
		predict_visits(it);
		item_count++;
	endtask

	// hold the sender until all results are in and the block has settled
	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		while (visit_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do begin
			@(posedge clk);
		end while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_VERTEX_COUNT)
			vc_reg = value;
		else
			undir_reg = value[0];
		@(posedge clk);
	endtask

	// both registers, written only once the block is idle
	task automatic set_config(input int vc, input bit und);
		wait_idle();
		write_reg(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
		write_reg(CFG_UNDIRECTED, {CFG_PAD_W'($urandom_range(15)), und});
	endtask

	// write every unwritten entry of the square in use so a search never reads garbage
	task automatic fill_square(input int vc, input int density);
		int n;
		n = (vc > NV) ? NV : vc;
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				if (!row_written[r][c])
					send_item(edge_item(r, c, $urandom_range(99) < density));
	endtask

	task automatic test_small_graphs();
		logic [15:0] tri_mask;
		// edges 0-0, 0-1, 0-3, 1-2 over a 4x4 square, bit r*4+c
		tri_mask = 16'h004B;
		send_item(edge_item(15, 15, 1'b1));
		send_item(edge_item(15, 0, 1'b0));
		set_config(4, 1'b1);
		for (int r = 0; r < 4; r++)
			for (int c = r; c < 4; c++)
				send_item(edge_item(r, c, tri_mask[r*4+c]));
		send_item(search_item(0));
		send_item(search_item(2));
		send_item(search_item(3));
		send_item(search_item(4));
		send_item(search_item(15));
		// directed writes touch one entry only
		set_config(4, 1'b0);
		send_item(edge_item(2, 1, 1'b0));
		send_item(edge_item(3, 2, 1'b1));
		send_item(search_item(2));
		send_item(search_item(3));
		// single vertex with a self loop
		set_config(1, 1'b0);
		send_item(search_item(0));
		send_item(search_item(1));
		// zero vertices: every start is bad
		set_config(0, 1'b1);
		send_item(search_item(0));
		wait_idle();
	endtask

	task automatic random_phase(input int count);
		int n;
		int density;
		int start_v;
		density = 10 + 20 * $urandom_range(4);
		n = (vc_reg > NV) ? NV : int'(vc_reg);
		fill_square(int'(vc_reg), density);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(3) != 0) begin
				if (n > 0 && $urandom_range(9) != 0)
					start_v = $urandom_range(n - 1);
				else
					start_v = $urandom_range(15);
				send_item(search_item(start_v));
			end else begin
				send_item(edge_item($urandom_range(15), $urandom_range(15),
					$urandom_range(99) < density));
			end
		end
	endtask

	task automatic test_random_graphs(input int target);
		int vc;
		while (item_count < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3: vc = $urandom_range(6, 2);
				4, 5:       vc = $urandom_range(16, 7);
				6:          vc = 16;
				7:          vc = $urandom_range(31, 17);
				8:          vc = $urandom_range(1, 0);
				default:    vc = $urandom_range(31);
			endcase
			set_config(vc, 1'($urandom_range(1)));
			random_phase($urandom_range(28, 12));
		end
		wait_idle();
	endtask

	// receiver stalls a long time while searches keep coming
	task automatic test_backpressure();
		set_config(16, 1'b1);
		fill_square(16, 70);
		hold_req_cnt <= hold_req_cnt + 1;
		for (int i = 0; i < 25; i++)
			send_item(search_item($urandom_range(15)));
		wait_idle();
	endtask

	// back-to-back items with no idling on either side
	task automatic test_steady_stream();
		set_config(31, 1'b0);
		idle_pct = 0;
		random_phase(60);
		wait_idle();
		idle_pct = IDLE_PCT;
	endtask

	// result ready: random stalls and requested long hold-offs
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_ch.ready <= 1'b0;
			hold_left    <= hold_left - 1;
		end else if (hold_done_cnt != hold_req_cnt) begin
			hold_done_cnt <= hold_req_cnt;
			hold_left     <= HOLD_CYCLES;
			res_ch.ready  <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// compare each result item with the oldest expected visit
	always @(posedge clk) begin : check_visit
		visit_t want;
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			result_count++;
			if (visit_q.size() == 0) begin
				$error("unexpected result item: vertex %0d last %0b bad_start %0b",
					res_ch.vertex, res_ch.last, res_ch.bad_start);
				fail_count++;
			end else begin
				want = visit_q.pop_front();
				if (res_ch.vertex !== want.vertex) begin
					$error("vertex: expected %0d, got %0d", want.vertex, res_ch.vertex);
					fail_count++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, res_ch.last);
					fail_count++;
				end
				if (res_ch.bad_start !== want.bad_start) begin
					$error("bad_start: expected %0b, got %0b", want.bad_start,
						res_ch.bad_start);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("run limit of %0d cycles reached", CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_EDGE;
		cmd_ch.from_vertex  = '0;
		cmd_ch.to_vertex    = '0;
		cmd_ch.edge_present = 1'b0;
		cmd_ch.start_vertex = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = CFG_VERTEX_COUNT;
		cfg_ch.data         = '0;
		res_ch.ready        = 1'b0;
		for (int r = 0; r < NV; r++) begin
			adj_rows[r]    = '0;
			row_written[r] = '0;
		end
		vc_reg    = VERTEX_COUNT_RST;
		undir_reg = UNDIRECTED_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_graphs();
		test_random_graphs(380);
		test_backpressure();
		test_steady_stream();

		wait_idle();
		repeat (20) @(posedge clk);
		$display("sent %0d items including %0d searches (%0d with a bad start)",
			item_count, search_count, bad_count);
		$display("checked %0d result items over vertex counts 0..31, both edge modes",
			result_count);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
